// ===== hdl/lcrs_pkg.sv =====
// ----------------------------------------------------------------------------
// lcrs_pkg: shared types and constants for the coefficient rejection sampler
// Holds the register map, the mode codes, the reset values and the structs
// that pass configuration, results and queue pushes between the modules.
// ----------------------------------------------------------------------------
`default_nettype none

package lcrs_pkg;

    // Sampler modes (code 3 selects no sampler)
    localparam logic [1:0] MODE_UNIFORM = 2'd0;
    localparam logic [1:0] MODE_ETA     = 2'd1;
    localparam logic [1:0] MODE_GAMMA   = 2'd2;

    // Register indexes (byte address = 4 * index)
    localparam logic [2:0] REG_MODE    = 3'd0;
    localparam logic [2:0] REG_TARGET  = 3'd1;
    localparam logic [2:0] REG_MODULUS = 3'd2;
    localparam logic [2:0] REG_ETA     = 3'd3;
    localparam logic [2:0] REG_GAMMA1  = 3'd4;

    // Field widths
    localparam int COEF_W   = 24;
    localparam int INDEX_W  = 10;
    localparam int TARGET_W = 10;
    localparam int MOD_W    = 23;
    localparam int ETA_W    = 3;
    localparam int GAMMA_W  = 20;
    localparam int ADDR_W   = 5;

    // Default count width
    localparam int COUNT_WIDTH_DEF = 10;

    // Reset values
    localparam logic [1:0]          RST_MODE    = MODE_UNIFORM;
    localparam logic [TARGET_W-1:0] RST_TARGET  = 10'd256;
    localparam logic [MOD_W-1:0]    RST_MODULUS = 23'd8380417;
    localparam logic [ETA_W-1:0]    RST_ETA     = 3'd3;
    localparam logic [GAMMA_W-1:0]  RST_GAMMA1  = 20'd523776;

    // Eta values at or below this use 3-bit fields
    localparam logic [ETA_W-1:0]    ETA_NARROW_MAX = 3'd3;

    // Output queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic [1:0]          mode;
        logic [TARGET_W-1:0] target;
        logic [MOD_W-1:0]    modulus;
        logic [ETA_W-1:0]    eta;
        logic [GAMMA_W-1:0]  gamma1;
    } t_cfg;

    typedef struct packed {
        logic                reached;
        logic [INDEX_W-1:0]  index;
        logic [COEF_W-1:0]   coef;
    } t_result;

    typedef struct packed {
        logic [1:0] num;     // results pushed this cycle (0..2)
        t_result    res0;
        t_result    res1;
    } t_push;

endpackage

`default_nettype wire

// ===== hdl/lcrs_cfg.sv =====
// ----------------------------------------------------------------------------
// lcrs_cfg: configuration register file
// APB-style write/read port holding mode, target, modulus, eta and gamma1.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_cfg (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [lcrs_pkg::ADDR_W-1:0]   paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    output lcrs_pkg::t_cfg                o_cfg
);
    import lcrs_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign o_cfg   = r_cfg;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.mode    <= RST_MODE;
            r_cfg.target  <= RST_TARGET;
            r_cfg.modulus <= RST_MODULUS;
            r_cfg.eta     <= RST_ETA;
            r_cfg.gamma1  <= RST_GAMMA1;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MODE:    r_cfg.mode    <= pwdata[1:0];
                REG_TARGET:  r_cfg.target  <= pwdata[TARGET_W-1:0];
                REG_MODULUS: r_cfg.modulus <= pwdata[MOD_W-1:0];
                REG_ETA:     r_cfg.eta     <= pwdata[ETA_W-1:0];
                REG_GAMMA1:  r_cfg.gamma1  <= pwdata[GAMMA_W-1:0];
                default: ;
            endcase
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_MODE:    prdata = 32'(r_cfg.mode);
            REG_TARGET:  prdata = 32'(r_cfg.target);
            REG_MODULUS: prdata = 32'(r_cfg.modulus);
            REG_ETA:     prdata = 32'(r_cfg.eta);
            REG_GAMMA1:  prdata = 32'(r_cfg.gamma1);
            default:     prdata = 32'd0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/lcrs_core.sv =====
// ----------------------------------------------------------------------------
// lcrs_core: byte register, group assembly and rejection tests
// Registers one byte, then in one pass builds candidates, applies the bound
// tests and the target count, and pushes up to two results to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_core #(
    parameter int COUNT_WIDTH = lcrs_pkg::COUNT_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lcrs_pkg::t_cfg       i_cfg,
    input  wire                  i_valid,
    output logic                 o_ready,
    input  wire  [7:0]           i_byte,
    input  wire                  i_last,
    input  wire                  i_room,
    output lcrs_pkg::t_push      o_push
);
    import lcrs_pkg::*;

    localparam int CMP_W = ((COUNT_WIDTH > INDEX_W) ? COUNT_WIDTH : INDEX_W) + 1;
    localparam int EXT_W = COUNT_WIDTH + INDEX_W;

    // Input register
    logic             r_in_valid;
    logic [7:0]       r_in_byte;
    logic             r_in_last;

    // Sampler state
    logic [2:0]             r_phase, n_phase;
    logic [31:0]            r_held,  n_held;
    logic [COUNT_WIDTH-1:0] r_count, n_count;

    logic        proc;
    logic [7:0]  b, hb0, hb1, hb2, hb3;
    logic [3:0]  eta_lo, eta_hi, eta_lim, grp_size;
    logic [22:0] v_uni;
    logic [19:0] v_g0, v_g1;
    logic [21:0] g_lim;
    logic        cand0_ok, cand1_ok;
    logic [COEF_W-1:0] cand0_val, cand1_val;

    logic [CMP_W-1:0]       cnt_e0, cnt_e1, tgt_e;
    logic [COUNT_WIDTH-1:0] cnt1;
    logic [EXT_W-1:0]       idx_e0, idx_e1;
    logic                   emit0, emit1;
    t_result                res0, res1;

    assign proc    = r_in_valid & i_room;
    assign o_ready = ~r_in_valid | proc;

    // Capture the next byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_in_byte <= i_byte;
            r_in_last <= i_last;
        end
    end

    assign b   = r_in_byte;
    assign hb0 = r_held[7:0];
    assign hb1 = r_held[15:8];
    assign hb2 = r_held[23:16];
    assign hb3 = r_held[31:24];

    assign v_uni   = {b[6:0], hb1, hb0};
    assign v_g0    = {hb2[3:0], hb1, hb0};
    assign v_g1    = {b, hb3, hb2[7:4]};
    assign g_lim   = {1'b0, i_cfg.gamma1, 1'b0};
    assign eta_lim = {i_cfg.eta, 1'b0};

    // Candidate values and next group state
    always_comb begin
        cand0_ok  = 1'b0;
        cand1_ok  = 1'b0;
        cand0_val = '0;
        cand1_val = '0;
        n_phase   = 3'd0;
        n_held    = 32'd0;
        eta_lo    = '0;
        eta_hi    = '0;
        grp_size  = (i_cfg.mode == MODE_UNIFORM) ? 4'd3 : 4'd5;
        case (i_cfg.mode)
            MODE_ETA: begin
                if (i_cfg.eta <= ETA_NARROW_MAX) begin
                    eta_lo = {1'b0, b[2:0]};
                    eta_hi = {1'b0, b[7:5]};
                end else begin
                    eta_lo = b[3:0];
                    eta_hi = b[7:4];
                end
                cand0_ok  = (eta_lo <= eta_lim);
                cand1_ok  = (eta_hi <= eta_lim);
                cand0_val = COEF_W'(i_cfg.modulus) + COEF_W'(i_cfg.eta) - COEF_W'(eta_lo);
                cand1_val = COEF_W'(i_cfg.modulus) + COEF_W'(i_cfg.eta) - COEF_W'(eta_hi);
            end
            MODE_UNIFORM, MODE_GAMMA: begin
                if (({1'b0, r_phase} + 4'd1) >= grp_size) begin
                    // group complete: present byte is its last
                    if (i_cfg.mode == MODE_UNIFORM) begin
                        cand0_ok  = (v_uni < i_cfg.modulus);
                        cand0_val = COEF_W'(v_uni);
                    end else begin
                        cand0_ok  = ((22'(v_g0) + 22'd2) <= g_lim);
                        cand1_ok  = ((22'(v_g1) + 22'd2) <= g_lim);
                        cand0_val = COEF_W'(i_cfg.modulus) + COEF_W'(i_cfg.gamma1)
                                    - COEF_W'(1) - COEF_W'(v_g0);
                        cand1_val = COEF_W'(i_cfg.modulus) + COEF_W'(i_cfg.gamma1)
                                    - COEF_W'(1) - COEF_W'(v_g1);
                    end
                end else begin
                    // hold byte in lane selected by phase
                    for (int i = 0; i < 4; i++) begin
                        n_held[8*i +: 8] = r_held[8*i +: 8]
                                         | ((r_phase[1:0] == 2'(i)) ? b : 8'd0);
                    end
                    n_phase = r_phase + 3'd1;
                end
            end
            default: ;
        endcase
    end

    // Target count gating and result fields
    assign tgt_e  = CMP_W'(i_cfg.target);
    assign cnt_e0 = CMP_W'(r_count);
    assign emit0  = cand0_ok & (cnt_e0 < tgt_e);
    assign cnt1   = emit0 ? (r_count + COUNT_WIDTH'(1)) : r_count;
    assign cnt_e1 = CMP_W'(cnt1);
    assign emit1  = cand1_ok & (cnt_e1 < tgt_e);
    assign idx_e0 = EXT_W'(r_count);
    assign idx_e1 = EXT_W'(cnt1);
    assign n_count = emit1 ? (cnt1 + COUNT_WIDTH'(1)) : cnt1;

    assign res0.coef    = cand0_val;
    assign res0.index   = idx_e0[INDEX_W-1:0];
    assign res0.reached = ((cnt_e0 + CMP_W'(1)) == tgt_e);
    assign res1.coef    = cand1_val;
    assign res1.index   = idx_e1[INDEX_W-1:0];
    assign res1.reached = ((cnt_e1 + CMP_W'(1)) == tgt_e);

    // Compact the emitted results into the first slots
    always_comb begin
        o_push.num  = proc ? ({1'b0, emit0} + {1'b0, emit1}) : 2'd0;
        o_push.res0 = emit0 ? res0 : res1;
        o_push.res1 = res1;
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= 3'd0;
            r_held  <= 32'd0;
            r_count <= '0;
        end else if (proc) begin
            if (r_in_last) begin
                r_phase <= 3'd0;
                r_held  <= 32'd0;
                r_count <= '0;
            end else begin
                r_phase <= n_phase;
                r_held  <= n_held;
                r_count <= n_count;
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lcrs_queue.sv =====
// ----------------------------------------------------------------------------
// lcrs_queue: result queue
// Small register queue taking up to two results per cycle and handing out
// one per cycle on the stream output while the receiver is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module lcrs_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  lcrs_pkg::t_push      i_push,
    output logic                 o_room,
    output logic                 o_valid,
    input  wire                  i_ready,
    output lcrs_pkg::t_result    o_res
);
    import lcrs_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    t_result          r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wp, r_rp;
    logic [PTR_W:0]   r_cnt;
    logic             pop;
    logic [PTR_W-1:0] wp1;

    assign o_valid = (r_cnt != '0);
    assign o_room  = (r_cnt <= (PTR_W+1)'(QUEUE_DEPTH - 2));
    assign pop     = o_valid & i_ready;
    assign wp1     = r_wp + PTR_W'(1);
    assign o_res   = r_mem[r_rp];

    // Entry writes
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (i_push.num != 2'd0 && r_wp == PTR_W'(i)) begin
                r_mem[i] <= i_push.res0;
            end else if (i_push.num == 2'd2 && wp1 == PTR_W'(i)) begin
                r_mem[i] <= i_push.res1;
            end
        end
    end

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= r_wp + PTR_W'(i_push.num);
            r_rp  <= r_rp + PTR_W'(pop);
            r_cnt <= r_cnt + (PTR_W+1)'(i_push.num) - (PTR_W+1)'(pop);
        end
    end

endmodule

`default_nettype wire

// ===== hdl/lattice_coefficient_rejection_sampler.sv =====
// Path: an accepted byte is held in the input register, then its coefficients are written
// into the result queue. Throughput: one byte per cycle while the queue has room; results
// leave at one per cycle while the receiver is ready, so bytes yielding two coefficients
// fill the queue. Input stalls only when the result queue lacks room for two results.
// Reset (i_rst_n low, synchronous) clears group, count and queue state and
// loads the register defaults; no clearing pass.
// ----------------------------------------------------------------------------
// lattice_coefficient_rejection_sampler: top level
// Streams random bytes in and accepted polynomial coefficients out, with an
// APB-style register port for mode, target, modulus, eta and gamma1.
// ----------------------------------------------------------------------------
`default_nettype none

module lattice_coefficient_rejection_sampler #(
    parameter int COUNT_WIDTH = lcrs_pkg::COUNT_WIDTH_DEF
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    // byte input
    input  wire                          s_axis_tvalid,
    output logic                         s_axis_tready,
    input  wire  [7:0]                   s_axis_tdata,   // [7:0] data_byte
    input  wire                          s_axis_tlast,   // last_byte
    // coefficient output
    output logic                         m_axis_tvalid,
    input  wire                          m_axis_tready,
    output logic [39:0]                  m_axis_tdata,   // [23:0] coefficient,
                                                         // [33:24] coeff_index
    output logic                         m_axis_tlast,   // count_reached
    // register port
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [lcrs_pkg::ADDR_W-1:0]  paddr,
    input  wire  [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import lcrs_pkg::*;

    t_cfg    cfg;
    t_push   push;
    t_result head;
    logic    room;

    lcrs_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    lcrs_core #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .i_room  (room),
        .o_push  (push)
    );

    lcrs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (head)
    );

    // Output packing
    assign m_axis_tdata = {6'd0, head.index, head.coef};
    assign m_axis_tlast = head.reached;

endmodule

`default_nettype wire

// ===== tb/sv/tb_lattice_coefficient_rejection_sampler.sv =====
// ----------------------------------------------------------------------------
// tb_lattice_coefficient_rejection_sampler: self-checking testbench
// Streams random bytes into the sampler under random backpressure and gaps,
// predicts every accepted coefficient from its own copy of the registers and
// sampling state, and checks each coefficient request leaving the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_lattice_coefficient_rejection_sampler;
    import lcrs_pkg::*;

    localparam int COUNT_W        = COUNT_WIDTH_DEF;
    localparam int UNI_GROUP      = 3;
    localparam int GAMMA_GROUP    = 5;
    localparam int DRAIN_CYCLES   = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int RANDOM_ITEMS   = 1300;
    localparam int FULL_POLY_LEN  = 600;
    localparam int FREEZE_CYCLES  = 200;

    localparam int unsigned UNI_TOP_MASK  = 32'h7F;
    localparam int unsigned GAMMA_MASK    = 32'hFFFFF;
    localparam int unsigned ETA_LO3_MASK  = 32'h07;
    localparam int unsigned ETA_LO4_MASK  = 32'h0F;
    localparam int unsigned MODE_NONE     = 3;
    localparam int unsigned MODULUS_MAX   = 32'h7FFFFF;
    localparam int unsigned TARGET_MAX    = 1023;
    localparam int unsigned GAMMA1_MAX    = 524288;

    // clock and reset
    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    // byte input
    logic        s_axis_tvalid = 1'b0;
    wire         s_axis_tready;
    logic [7:0]  s_axis_tdata  = '0;  // [7:0] data_byte
    logic        s_axis_tlast  = 1'b0; // last_byte

    // coefficient output
    wire         m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    wire  [39:0] m_axis_tdata;        // [23:0] coefficient, [33:24] coeff_index
    wire         m_axis_tlast;        // count_reached

    // register port
    logic              psel    = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite  = 1'b0;
    logic [ADDR_W-1:0] paddr   = '0;
    logic [31:0]       pwdata  = '0;
    wire  [31:0]       prdata;
    wire               pready;

    lattice_coefficient_rejection_sampler i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // predictor copy of the registers and sampling state
    logic [1:0]  cfg_mode;
    int unsigned cfg_target;
    int unsigned cfg_modulus;
    int unsigned cfg_eta;
    int unsigned cfg_gamma1;
    int unsigned grp_phase;
    int unsigned grp_bytes;
    int unsigned coef_count;

    t_result pending_coefs[$];

    int mismatches  = 0;
    int bytes_sent  = 0;
    bit idle_on     = 1'b0;
    int rx_freeze   = 0;
    int rx_stall    = 0;
    int quiet_count = 0;

    // mostly short, a few long
    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80) return $urandom_range(1, 3);
        if (r < 96) return $urandom_range(4, 15);
        return $urandom_range(20, 80);
    endfunction

    function automatic int pick_tx_gap();
        if (!idle_on || $urandom_range(0, 99) < 60) return 0;
        return pick_len();
    endfunction

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------
    task automatic push_coef(input int unsigned value);
        t_result r;
        if (coef_count >= cfg_target) return;
        r.coef    = value[COEF_W-1:0];
        r.index   = coef_count[INDEX_W-1:0];
        r.reached = (coef_count + 1 == cfg_target);
        pending_coefs.push_back(r);
        coef_count = (coef_count + 1) & ((1 << COUNT_W) - 1);
    endtask

    task automatic take_eta_field(input int unsigned v);
        if (v <= 2 * cfg_eta) push_coef(cfg_modulus + cfg_eta - v);
    endtask

    task automatic take_gamma_field(input int unsigned v);
        if (v + 2 <= 2 * cfg_gamma1) push_coef(cfg_modulus + cfg_gamma1 - 1 - v);
    endtask

    task automatic predict_coefs(input logic [7:0] data, input logic last);
        int unsigned b, b0, b1, b2, b3, grp, v;
        b = 32'(data);
        if (cfg_mode == MODE_ETA) begin
            if (cfg_eta <= ETA_NARROW_MAX) begin
                take_eta_field(b & ETA_LO3_MASK);
                take_eta_field(b >> 5);
            end else begin
                take_eta_field(b & ETA_LO4_MASK);
                take_eta_field(b >> 4);
            end
            grp_phase = 0;
            grp_bytes = 0;
        end else if (cfg_mode == MODE_UNIFORM || cfg_mode == MODE_GAMMA) begin
            grp = (cfg_mode == MODE_UNIFORM) ? UNI_GROUP : GAMMA_GROUP;
            if (grp_phase + 1 >= grp) begin
                b0 = grp_bytes & 8'hFF;
                b1 = (grp_bytes >> 8) & 8'hFF;
                b2 = (grp_bytes >> 16) & 8'hFF;
                b3 = (grp_bytes >> 24) & 8'hFF;
                if (cfg_mode == MODE_UNIFORM) begin
                    v = b0 | (b1 << 8) | ((b & UNI_TOP_MASK) << 16);
                    if (v < cfg_modulus) push_coef(v);
                end else begin
                    take_gamma_field((b0 | (b1 << 8) | (b2 << 16)) & GAMMA_MASK);
                    take_gamma_field((b2 >> 4) | (b3 << 4) | (b << 12));
                end
                grp_phase = 0;
                grp_bytes = 0;
            end else begin
                grp_bytes = grp_bytes | (b << (8 * (grp_phase & 3)));
                grp_phase = (grp_phase + 1) & 7;
            end
        end else begin
            grp_phase = 0;
            grp_bytes = 0;
        end
        // last byte clears the group and the count
        if (last) begin
            grp_phase  = 0;
            grp_bytes  = 0;
            coef_count = 0;
        end
    endtask

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] data, input logic last);
        int  gap;
        logic rdy;
        gap = pick_tx_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= data;
        s_axis_tlast  <= last;
        do begin
            @(negedge i_clk);
            rdy = s_axis_tready;
            @(posedge i_clk);
        end while (!rdy);
        predict_coefs(data, last);
        bytes_sent++;
    endtask

    task automatic write_reg(input logic [2:0] idx, input int unsigned value);
        logic rdy;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            rdy = pready;
            @(posedge i_clk);
        end while (!rdy);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_MODE:    cfg_mode    = value[1:0];
            REG_TARGET:  cfg_target  = value & 32'h3FF;
            REG_MODULUS: cfg_modulus = value & MODULUS_MAX;
            REG_ETA:     cfg_eta     = value & 32'h7;
            REG_GAMMA1:  cfg_gamma1  = value & GAMMA_MASK;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    // stop sending, let every pending coefficient drain, then let the pipe settle
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_coefs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic send_buffer(input int len, input bit terminate);
        logic last;
        for (int i = 0; i < len; i++) begin
            last = (terminate && i == len - 1) || ($urandom_range(0, 59) == 0);
            send_byte(8'($urandom_range(0, 255)), last);
        end
    endtask

    // ------------------------------------------------------------------
    // receiver: random stalls plus a long freeze on request
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_freeze > 0) begin
            m_axis_tready <= 1'b0;
            rx_freeze = rx_freeze - 1;
        end else if (rx_stall > 0) begin
            m_axis_tready <= 1'b0;
            rx_stall = rx_stall - 1;
        end else if (idle_on && $urandom_range(0, 99) < 20) begin
            m_axis_tready <= 1'b0;
            rx_stall = pick_len() - 1;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // checker
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h", what, got, want);
        mismatches++;
    endtask

    always @(negedge i_clk) begin
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_coefs.size() == 0) begin
                report_mismatch("coefficient with none pending", m_axis_tdata[31:0], 0);
            end else begin
                want = pending_coefs.pop_front();
                if (m_axis_tdata[23:0] !== want.coef)
                    report_mismatch("coefficient", 32'(m_axis_tdata[23:0]),
                                    32'(want.coef));
                if (m_axis_tdata[33:24] !== want.index)
                    report_mismatch("coeff_index", 32'(m_axis_tdata[33:24]),
                                    32'(want.index));
                if (m_axis_tlast !== want.reached)
                    report_mismatch("count_reached", 32'(m_axis_tlast),
                                    32'(want.reached));
            end
        end
    end

    // watchdog on cycles without any accepted request
    always @(negedge i_clk) begin
        if (!i_rst_n || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready) || (psel && penable))
            quiet_count = 0;
        else
            quiet_count = quiet_count + 1;
        if (quiet_count >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_uniform_edges();
        // zero, top bit of third byte masked (value just under q), partial group
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hE0, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hAB, 1'b1);
        wait_drained();
    endtask

    task automatic test_eta_fields();
        write_reg(REG_MODE, 32'(MODE_ETA));
        send_byte(8'hFF, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'hC6, 1'b0);
        wait_drained();
        // wide fields with a tiny modulus: offset goes below zero
        write_reg(REG_ETA, 7);
        write_reg(REG_MODULUS, 2);
        send_byte(8'hFE, 1'b1);
        wait_drained();
    endtask

    task automatic test_gamma_edges();
        write_reg(REG_MODE, 32'(MODE_GAMMA));
        write_reg(REG_GAMMA1, GAMMA1_MAX);
        // first value at the bound, second just past it
        send_byte(8'hFE, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        send_byte(8'hFF, 1'b0);
        wait_drained();
    endtask

    task automatic test_special_cases();
        // mode switched mid group, with a target of one
        write_reg(REG_MODULUS, MODULUS_MAX);
        write_reg(REG_TARGET, 1);
        send_byte(8'h11, 1'b0);
        send_byte(8'h22, 1'b0);
        send_byte(8'h44, 1'b0);
        wait_drained();
        write_reg(REG_MODE, 32'(MODE_UNIFORM));
        send_byte(8'h33, 1'b1);
        wait_drained();
        // no sampler selected
        write_reg(REG_MODE, MODE_NONE);
        send_byte(8'h5A, 1'b0);
        wait_drained();
        // target zero emits nothing
        write_reg(REG_MODE, 32'(MODE_UNIFORM));
        write_reg(REG_TARGET, 0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h02, 1'b0);
        send_byte(8'h03, 1'b1);
        wait_drained();
    endtask

    task automatic test_backpressure();
        write_reg(REG_MODE, 32'(MODE_ETA));
        write_reg(REG_ETA, 7);
        write_reg(REG_TARGET, TARGET_MAX);
        idle_on   = 1'b0;
        rx_freeze = FREEZE_CYCLES;
        send_buffer(40, 1'b1);
        wait_drained();
    endtask

    task automatic test_full_polynomial();
        // enough bytes to fill the largest target
        write_reg(REG_MODE, 32'(MODE_ETA));
        write_reg(REG_ETA, 7);
        write_reg(REG_MODULUS, $urandom_range(2, MODULUS_MAX));
        write_reg(REG_TARGET, TARGET_MAX);
        idle_on = 1'b1;
        for (int i = 0; i < FULL_POLY_LEN; i++)
            send_byte(8'($urandom_range(0, 255)), i == FULL_POLY_LEN - 1);
        wait_drained();
    endtask

    task automatic test_random_buffers();
        int r, stop_at, nbuf;
        stop_at = bytes_sent + RANDOM_ITEMS;
        while (bytes_sent < stop_at) begin
            r = $urandom_range(0, 99);
            write_reg(REG_MODE, (r < 4) ? MODE_NONE : $urandom_range(0, 2));
            if ($urandom_range(0, 99) < 70) begin
                r = $urandom_range(0, 99);
                write_reg(REG_TARGET, (r < 8)  ? 0 :
                                      (r < 16) ? TARGET_MAX :
                                      (r < 70) ? $urandom_range(1, 40) :
                                                 $urandom_range(0, TARGET_MAX));
            end
            if ($urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 99);
                write_reg(REG_MODULUS, (r < 15) ? 2 :
                                       (r < 30) ? MODULUS_MAX :
                                       (r < 60) ? 32'(RST_MODULUS) :
                                                  $urandom_range(2, MODULUS_MAX));
            end
            if ($urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 99);
                write_reg(REG_ETA, (r < 25) ? 1 : (r < 50) ? 7 : $urandom_range(1, 7));
            end
            if ($urandom_range(0, 99) < 50) begin
                r = $urandom_range(0, 99);
                write_reg(REG_GAMMA1, (r < 10) ? GAMMA1_MAX :
                                      (r < 18) ? 2 :
                                      (r < 22) ? $urandom_range(0, 1) :
                                      (r < 65) ? $urandom_range(400000, GAMMA1_MAX) :
                                                 $urandom_range(2, GAMMA1_MAX));
            end
            idle_on = ($urandom_range(0, 3) != 0);
            nbuf = $urandom_range(1, 4);
            for (int k = 0; k < nbuf; k++)
                send_buffer(($urandom_range(0, 99) < 70) ? $urandom_range(3, 40)
                                                         : $urandom_range(41, 120),
                            $urandom_range(0, 9) != 0);
            wait_drained();
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        cfg_mode    = RST_MODE;
        cfg_target  = 32'(RST_TARGET);
        cfg_modulus = 32'(RST_MODULUS);
        cfg_eta     = 32'(RST_ETA);
        cfg_gamma1  = 32'(RST_GAMMA1);
        grp_phase   = 0;
        grp_bytes   = 0;
        coef_count  = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_uniform_edges();
        test_eta_fields();
        test_gamma_edges();
        test_special_cases();
        test_backpressure();
        test_full_polynomial();
        test_random_buffers();

        wait_drained();
        if (mismatches == 0 && pending_coefs.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
